### hdl/eqdo_pkg.sv
// eqdo_pkg: shared types, codes and constants of the event queue block
// used by every module of event_queue_drop_oldest and by its checker
package eqdo_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 64;
  localparam int unsigned DEF_NUM_DEVICES = 2;

  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned SEC_W    = 39;
  localparam int unsigned USEC_W   = 20;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // stamp split: stamp / 1000 and (stamp % 1000) * 1000
  localparam int unsigned MS_PER_SEC     = 1000;
  localparam int unsigned REM_W          = 10;
  localparam int unsigned DIV_STEP_BITS  = 4;
  localparam int unsigned DIV_STEPS      = STAMP_W / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_CODE = 1'b1;

  localparam logic [CODE_W-1:0] MARKER_RESET = 16'd3;

  typedef struct packed {
    logic                      func;
    logic                      device;
    logic [TYPE_W-1:0]         ev_type;
    logic [CODE_W-1:0]         ev_code;
    logic signed [VALUE_W-1:0] ev_value;
    logic [STAMP_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic                      event_valid;
    logic [SEC_W-1:0]          out_sec;
    logic [USEC_W-1:0]         out_usec;
    logic [TYPE_W-1:0]         out_type;
    logic [CODE_W-1:0]         out_code;
    logic signed [VALUE_W-1:0] out_value;
    logic [FILL_W-1:0]         fill_level;
    logic                      became_nonempty;
    logic [COUNT_W-1:0]        drop_total;
    logic [COUNT_W-1:0]        resync_total;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic finish;
  } eqdo_cmd_t;

  typedef struct packed {
    logic need_div;
  } eqdo_status_t;

endpackage

### hdl/eqdo_ctrl.sv
// eqdo_ctrl: sequencer of the event queue block
// depends on eqdo_pkg for command/status structs and divider step count
module eqdo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  eqdo_pkg::eqdo_status_t status_i,
  output eqdo_pkg::eqdo_cmd_t    cmd_o,
  output logic                  busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  localparam logic [eqdo_pkg::DIV_CNT_W-1:0] LAST_STEP =
    eqdo_pkg::DIV_CNT_W'(eqdo_pkg::DIV_STEPS - 1);

  state_e                          state_q, state_d;
  logic [eqdo_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = start;
        // only a pop that finds an event needs the stamp split
        if (start && status_i.need_div) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hdl/eqdo_datapath.sv
// eqdo_datapath: queue memory, per-device pointers and counters, stamp divider
// depends on eqdo_pkg for item structs, codes and constants
module eqdo_datapath #(
  parameter int unsigned QUEUE_DEPTH = eqdo_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned NUM_DEVICES = eqdo_pkg::DEF_NUM_DEVICES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  eqdo_pkg::in_item_t                item_i,
  input  logic                              cfg_we_i,
  input  logic [eqdo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [eqdo_pkg::CFG_W-1:0]        cfg_data_i,
  input  eqdo_pkg::eqdo_cmd_t               cmd_i,
  output eqdo_pkg::eqdo_status_t            status_o,
  output logic                              done_o,
  output eqdo_pkg::out_item_t               result_o
);

  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned DEV_W     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int unsigned OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W    = DEV_W + PTR_W;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);
  localparam logic [eqdo_pkg::REM_W:0] DIVISOR =
    (eqdo_pkg::REM_W + 1)'(eqdo_pkg::MS_PER_SEC);
  localparam logic [eqdo_pkg::USEC_W-1:0] USEC_SCALE =
    eqdo_pkg::USEC_W'(eqdo_pkg::MS_PER_SEC);

  typedef struct packed {
    logic [eqdo_pkg::TYPE_W-1:0]         ev_type;
    logic [eqdo_pkg::CODE_W-1:0]         ev_code;
    logic signed [eqdo_pkg::VALUE_W-1:0] ev_value;
    logic [eqdo_pkg::STAMP_W-1:0]        stamp;
  } entry_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // per-device control state
  logic [PTR_W-1:0]                 wp_q     [NUM_DEVICES];
  logic [PTR_W-1:0]                 rp_q     [NUM_DEVICES];
  logic [OCC_W-1:0]                 occ_q    [NUM_DEVICES];
  logic                             pend_q   [NUM_DEVICES];
  logic [eqdo_pkg::COUNT_W-1:0]     drop_q   [NUM_DEVICES];
  logic [eqdo_pkg::COUNT_W-1:0]     resync_q [NUM_DEVICES];

  logic [eqdo_pkg::TYPE_W-1:0]      sync_type_q;
  logic [eqdo_pkg::CODE_W-1:0]      marker_q;

  entry_t                           mem [MEM_DEPTH];
  entry_t                           rd_q;
  logic [DEV_W-1:0]                 dev_q;
  logic [eqdo_pkg::STAMP_W-1:0]     acc_q, acc_d;
  logic [eqdo_pkg::REM_W-1:0]       rem_q, rem_d;
  logic                             done_q;
  eqdo_pkg::out_item_t              res_q, imm_res, fin_res;

  logic [DEV_W-1:0]                 dev_idx;
  logic                             dev_ok;
  logic                             is_push;
  logic [PTR_W-1:0]                 cur_wp, cur_rp;
  logic [OCC_W-1:0]                 cur_occ, push_occ;
  logic [eqdo_pkg::COUNT_W-1:0]     cur_drop, push_drop;
  logic                             q_full, q_empty, pend_eff, mark;
  logic [eqdo_pkg::CODE_W-1:0]      push_code;
  logic                             resync_hit;
  logic [eqdo_pkg::USEC_W-1:0]      usec;

  assign dev_idx   = DEV_W'(item_i.device);
  assign dev_ok    = (32'(item_i.device) < NUM_DEVICES);
  assign is_push   = (item_i.func == eqdo_pkg::FUNC_PUSH);
  assign cur_wp    = wp_q[dev_idx];
  assign cur_rp    = rp_q[dev_idx];
  assign cur_occ   = occ_q[dev_idx];
  assign cur_drop  = drop_q[dev_idx];
  assign q_full    = (cur_occ == OCC_FULL);
  assign q_empty   = (cur_occ == '0);
  // a full ring loses its oldest item and arms the marker rewrite
  assign pend_eff  = q_full | pend_q[dev_idx];
  assign mark      = (item_i.ev_type == sync_type_q) && pend_eff;
  assign push_code = mark ? marker_q : item_i.ev_code;
  assign push_occ  = q_full ? cur_occ : cur_occ + 1'b1;
  assign push_drop = q_full ? cur_drop + 1'b1 : cur_drop;

  assign status_o.need_div = !is_push && dev_ok && !q_empty;

  assign resync_hit = (rd_q.ev_type == sync_type_q) && (rd_q.ev_code == marker_q);

  // stamp / 1000, restoring division DIV_STEP_BITS (4) quotient bits per step
  always_comb begin
    logic [eqdo_pkg::STAMP_W-1:0] a;
    logic [eqdo_pkg::REM_W:0]     r;
    logic [eqdo_pkg::REM_W-1:0]   rm;
    a  = acc_q;
    rm = rem_q;
    for (int k = 0; k < int'(eqdo_pkg::DIV_STEP_BITS); k++) begin
      r = {rm, a[eqdo_pkg::STAMP_W-1]};
      a = {a[eqdo_pkg::STAMP_W-2:0], 1'b0};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        a[0] = 1'b1;
      end
      rm = r[eqdo_pkg::REM_W-1:0];
    end
    acc_d = a;
    rem_d = rm;
  end

  assign usec = eqdo_pkg::USEC_W'(rem_q) * USEC_SCALE;

  // result of a push, an empty pop or an unknown device
  always_comb begin
    imm_res = '0;
    if (dev_ok) begin
      imm_res.fill_level      = eqdo_pkg::FILL_W'(is_push ? push_occ : cur_occ);
      imm_res.became_nonempty = is_push && (push_occ == OCC_W'(1));
      imm_res.drop_total      = is_push ? push_drop : cur_drop;
      imm_res.resync_total    = resync_q[dev_idx];
    end
  end

  always_comb begin
    fin_res                 = '0;
    fin_res.event_valid     = 1'b1;
    fin_res.out_sec         = acc_q[eqdo_pkg::SEC_W-1:0];
    fin_res.out_usec        = usec;
    fin_res.out_type        = rd_q.ev_type;
    fin_res.out_code        = rd_q.ev_code;
    fin_res.out_value       = rd_q.ev_value;
    fin_res.fill_level      = eqdo_pkg::FILL_W'(occ_q[dev_q]);
    fin_res.drop_total      = drop_q[dev_q];
    fin_res.resync_total    = resync_q[dev_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_DEVICES); i++) begin
        wp_q[i]     <= '0;
        rp_q[i]     <= '0;
        occ_q[i]    <= '0;
        pend_q[i]   <= 1'b0;
        drop_q[i]   <= '0;
        resync_q[i] <= '0;
      end
      sync_type_q <= '0;
      marker_q    <= eqdo_pkg::MARKER_RESET;
      done_q      <= 1'b0;
    end else begin
      if (cmd_i.accept && dev_ok) begin
        if (is_push) begin
          wp_q[dev_idx]   <= next_slot(cur_wp);
          if (q_full) begin
            rp_q[dev_idx] <= next_slot(cur_rp);
          end
          occ_q[dev_idx]  <= push_occ;
          drop_q[dev_idx] <= push_drop;
          pend_q[dev_idx] <= pend_eff & !mark;
        end else if (!q_empty) begin
          rp_q[dev_idx]   <= next_slot(cur_rp);
          occ_q[dev_idx]  <= cur_occ - 1'b1;
          drop_q[dev_idx] <= '0;
        end
      end
      if (cmd_i.load && resync_hit) begin
        resync_q[dev_q] <= resync_q[dev_q] + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          eqdo_pkg::CFG_SYNC_TYPE:   sync_type_q <= cfg_data_i;
          eqdo_pkg::CFG_MARKER_CODE: marker_q    <= cfg_data_i;
          default: ;
        endcase
      end
      done_q <= (cmd_i.accept && !status_o.need_div) || cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && dev_ok && is_push) begin
      mem[{dev_idx, cur_wp}] <= '{ev_type:  item_i.ev_type,
                                  ev_code:  push_code,
                                  ev_value: item_i.ev_value,
                                  stamp:    item_i.now_ms};
    end
    if (cmd_i.accept) begin
      rd_q  <= mem[{dev_idx, cur_rp}];
      dev_q <= dev_idx;
    end
    if (cmd_i.load) begin
      acc_q <= rd_q.stamp;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (cmd_i.accept) begin
      res_q <= imm_res;
    end else if (cmd_i.finish) begin
      res_q <= fin_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### hdl/event_queue_drop_oldest.sv
// event_queue_drop_oldest: per-device event rings with drop-oldest overflow
// Channels: an item (push or pop, device, event fields, ms time) enters on
// item_i when start is high and busy is low. Exactly one result item comes
// back on result_o, marked by done_o for a single cycle; the receiver must
// take it then, there is no back-pressure on the result side.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i at once
// (0 sync event type, 1 dropped marker code); write only while no item is
// in flight.
// Timing: a push, a pop on an empty queue or an item for an unknown device
// returns its result in the cycle after acceptance and busy stays low, so
// one such item per cycle. A pop that delivers an event reads the queue
// memory, then splits the stamp into seconds and microseconds in a shared
// divider that makes 4 quotient bits per cycle; its result shows after the
// load, divide and finish states, during which busy is high.
// Reset: all queues empty, counters and flags cleared, sync type 0 and
// marker code 3; the queue memory itself is not cleared.
module event_queue_drop_oldest #(
  parameter int unsigned QUEUE_DEPTH = eqdo_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned NUM_DEVICES = eqdo_pkg::DEF_NUM_DEVICES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  eqdo_pkg::in_item_t             item_i,
  input  logic                           cfg_we_i,
  input  logic [eqdo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eqdo_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                           done_o,
  output eqdo_pkg::out_item_t            result_o
);

  eqdo_pkg::eqdo_cmd_t    cmd;
  eqdo_pkg::eqdo_status_t status;

  eqdo_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  eqdo_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_DEVICES (NUM_DEVICES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

### hdl/eqdo_checker.sv
// eqdo_checker: port-level assertions for event_queue_drop_oldest
// depends on eqdo_pkg; attached to the top level by the bind below
module eqdo_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input eqdo_pkg::in_item_t   item_i,
  input logic                 done_o,
  input eqdo_pkg::out_item_t  result_o
);

  // a push always answers in the next cycle
  a_push_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.func == eqdo_pkg::FUNC_PUSH |=> done_o)
    else $error("push item without result in next cycle");

  // no result while a pop is still working
  a_no_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe while busy");

  // a delivered event always clears the drop count
  a_pop_clears_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.event_valid |-> result_o.drop_total == '0)
    else $error("delivered event with nonzero drop count");

  // only pushes report the queue turning nonempty
  a_nonempty_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.became_nonempty |-> !result_o.event_valid)
    else $error("pop result reports queue became nonempty");

  // microsecond part stays within one second
  a_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.event_valid |-> result_o.out_usec <= 20'd999000)
    else $error("microsecond field out of range");

endmodule

bind event_queue_drop_oldest eqdo_checker u_eqdo_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
